// ===== design/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned ArenaUnits = 16384;
  localparam int unsigned UnitBytes  = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NOTFREE = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    K_ALLOC = 1'b0,
    K_FREE  = 1'b1
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT0,
    S_INIT1,
    S_A_RD_ROVER,
    S_A_RD_P,
    S_A_CHECK,
    S_A_RD_NEXT,
    S_A_SPLIT_WR,
    S_A_FRONT_WR,
    S_F_RD_P,
    S_F_CHECK,
    S_F_RD_BP,
    S_F_RD_N2,
    S_F_MERGE_BP,
    S_F_RD_P2,
    S_F_MERGE_P,
    S_DONE
  } fsm_e;

endpackage

// ===== design/first_fit_free_list_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_top
// Address-ordered circular free list over one arena, first-fit from a rover.
// ----------------------------------------------------------------------------
//  channel  | signals                                      | direction
//  command  | start_i, busy_o, kind_i, request_bytes_i,    | in
//           | release_index_i                              |
//  result   | done_o, status_o, payload_index_o            | out (one cycle)
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i         | in
//
// For each free-list header visited, the walk issues one read of the single
// header memory, waits for the registered read data and compares. The first
// command after reset first writes the sentinel and the initial block. Reset
// clears the control state only; the header memory needs no clearing. busy_o
// stays high from the transfer of a command until its result strobe, which
// the receiver takes unconditionally.
module first_fit_free_list_allocator_top
  import ffa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [17:0] request_bytes_i,
  input  logic [13:0] release_index_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [13:0] payload_index_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(ArenaUnits);
  localparam int unsigned SW = AW + 1;          // block size may reach ArenaUnits-1
  localparam logic [SW-1:0] LastSize = SW'(ArenaUnits - 1);
  localparam int unsigned StepW = AW + 2;
  localparam logic [StepW-1:0] StepLimit = StepW'(ArenaUnits + 2);

  typedef struct packed {
    logic [SW-1:0] size;
    logic [AW-1:0] next;
  } hdr_t;

  // header memory: one write port, one read port, registered read
  hdr_t            mem [ArenaUnits];
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  hdr_t            wdata, rdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  fsm_e             state_q, state_d;
  logic             init_q, init_d;
  logic [AW-1:0]    rover_q, rover_d;
  logic [6:0]       split_q;
  logic             kind_q;
  logic [SW:0]      need_q, need_d;      // wide enough for bytes/16 + 1
  logic [AW-1:0]    bp_q, bp_d;
  logic [AW-1:0]    prev_q, prev_d, p_q, p_d, n2_q, n2_d;
  hdr_t             hp_q, hp_d, hbp_q, hbp_d;
  logic [StepW-1:0] steps_q, steps_d;
  logic [1:0]       status_q, status_d;
  logic [13:0]      pay_q, pay_d;
  logic             done_q, done_d;
  logic             bad_idx_q;

  assign cfg_ready_o     = (state_q == S_IDLE);
  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign payload_index_o = pay_q;

  logic accept;
  assign accept = start_i && !busy_o;

  // byte count to units: ceil(b/16) + 1 header unit, zero treated as one byte
  logic [17:0] bytes_eff;
  logic [14:0] units_raw;
  assign bytes_eff = (request_bytes_i == '0) ? 18'd1 : request_bytes_i;
  assign units_raw = 15'((19'(bytes_eff) + 19'(UnitBytes - 1)) >> 4) + 15'd1;

  logic [6:0] split_eff;
  assign split_eff = (split_q == '0) ? 7'd1 : split_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      init_q   <= 1'b0;
      rover_q  <= '0;
      split_q  <= 7'd2;
      done_q   <= 1'b0;
      steps_q  <= '0;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      rover_q  <= rover_d;
      done_q   <= done_d;
      steps_q  <= steps_d;
      if (cfg_valid_i && cfg_ready_o) begin
        split_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    need_q   <= need_d;
    bp_q     <= bp_d;
    prev_q   <= prev_d;
    p_q      <= p_d;
    n2_q     <= n2_d;
    hp_q     <= hp_d;
    hbp_q    <= hbp_d;
    status_q <= status_d;
    pay_q    <= pay_d;
    if (accept) begin
      kind_q    <= kind_i;
      bad_idx_q <= (release_index_i < 14'd2) || (32'(release_index_i) >= ArenaUnits);
    end
  end

  // shared compare terms
  logic [SW:0] rem;
  logic [AW:0] p_end;
  logic [AW:0] bp_end;
  assign rem    = (SW+1)'(hp_q.size) - need_q;
  assign p_end  = (AW+1)'(p_q) + (AW+1)'(hp_q.size);
  assign bp_end = (AW+1)'(bp_q) + (AW+1)'(hbp_q.size);

  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    rover_d  = rover_q;
    need_d   = need_q;
    bp_d     = bp_q;
    prev_d   = prev_q;
    p_d      = p_q;
    n2_d     = n2_q;
    hp_d     = hp_q;
    hbp_d    = hbp_q;
    steps_d  = steps_q;
    status_d = status_q;
    pay_d    = pay_q;
    done_d   = 1'b0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr    = p_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          need_d  = (SW+1)'(units_raw);
          bp_d    = AW'(release_index_i - 14'd1);
          steps_d = '0;
          pay_d   = '0;
          state_d = init_q ? ((kind_i == K_FREE) ? S_F_RD_P : S_A_RD_ROVER) : S_INIT0;
          p_d     = rover_q;
          prev_d  = rover_q;
          raddr   = rover_q;
        end
      end
      S_INIT0: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = '{size: '0, next: AW'(1)};
        state_d = S_INIT1;
      end
      S_INIT1: begin
        we      = 1'b1;
        waddr   = AW'(1);
        wdata   = '{size: LastSize, next: '0};
        init_d  = 1'b1;
        rover_d = '0;
        p_d     = '0;
        prev_d  = '0;
        state_d = (kind_q == K_FREE) ? S_F_RD_P : S_A_RD_ROVER;
      end
      // ---------------- allocate ----------------
      S_A_RD_ROVER: begin
        raddr   = prev_q;
        state_d = S_A_RD_NEXT;
      end
      S_A_RD_NEXT: begin
        // rdata is header of prev; follow its link
        p_d     = rdata.next;
        hbp_d   = rdata;           // keep prev header
        state_d = S_A_RD_P;
      end
      S_A_RD_P: begin
        raddr   = p_q;
        state_d = S_A_CHECK;
      end
      S_A_CHECK: begin
        hp_d = rdata;
        if (steps_q >= StepLimit) begin
          status_d = ST_NOFIT;
          state_d  = S_DONE;
        end else if ((SW+1)'(rdata.size) >= need_q) begin
          state_d = S_A_SPLIT_WR;
        end else if (p_q == rover_q) begin
          status_d = ST_NOFIT;
          state_d  = S_DONE;
        end else begin
          steps_d = steps_q + StepW'(1);
          prev_d  = p_q;
          hbp_d   = rdata;
          p_d     = rdata.next;
          state_d = S_A_RD_P;
        end
      end
      S_A_SPLIT_WR: begin
        we       = 1'b1;
        rover_d  = prev_q;
        status_d = ST_OK;
        if (rem < (SW+1)'(split_eff)) begin
          waddr   = prev_q;
          wdata   = '{size: hbp_q.size, next: hp_q.next};
          pay_d   = 14'(AW'(p_q + AW'(1)));
          state_d = S_DONE;
        end else begin
          waddr   = p_q;
          wdata   = '{size: SW'(rem), next: hp_q.next};
          p_d     = AW'(p_end - (AW+1)'(need_q));
          state_d = S_A_FRONT_WR;
        end
      end
      S_A_FRONT_WR: begin
        we      = 1'b1;
        waddr   = p_q;
        wdata   = '{size: SW'(need_q), next: '0};
        pay_d   = 14'(AW'(p_q + AW'(1)));
        state_d = S_DONE;
      end
      // ---------------- free ----------------
      S_F_RD_P: begin
        if (bad_idx_q) begin
          status_d = ST_NOTFREE;
          state_d  = S_DONE;
        end else begin
          raddr   = p_q;
          state_d = S_F_CHECK;
        end
      end
      S_F_CHECK: begin
        hp_d = rdata;
        if (steps_q >= StepLimit) begin
          status_d = ST_NOTFREE;
          state_d  = S_DONE;
        end else if (p_q <= bp_q &&
                     ((AW+1)'(p_q) + (AW+1)'(rdata.size)) > (AW+1)'(bp_q)) begin
          status_d = ST_NOTFREE;
          state_d  = S_DONE;
        end else if ((bp_q > p_q && bp_q < rdata.next) ||
                     (p_q >= rdata.next && bp_q > p_q)) begin
          n2_d    = rdata.next;
          raddr   = bp_q;
          state_d = S_F_RD_BP;
        end else begin
          steps_d = steps_q + StepW'(1);
          p_d     = rdata.next;
          state_d = S_F_RD_P;
        end
      end
      S_F_RD_BP: begin
        hbp_d   = rdata;
        raddr   = n2_q;
        state_d = S_F_RD_N2;
      end
      S_F_RD_N2: begin
        state_d = S_F_MERGE_BP;
        raddr   = n2_q;
      end
      S_F_MERGE_BP: begin
        we    = 1'b1;
        waddr = bp_q;
        if (bp_end == (AW+1)'(n2_q)) begin
          wdata = '{size: SW'(hbp_q.size + rdata.size), next: rdata.next};
        end else begin
          wdata = '{size: hbp_q.size, next: n2_q};
        end
        hbp_d   = wdata;            // forward the fresh bp header
        state_d = S_F_MERGE_P;
      end
      S_F_MERGE_P: begin
        we    = 1'b1;
        waddr = p_q;
        if (p_end == (AW+1)'(bp_q)) begin
          wdata = '{size: SW'(hp_q.size + hbp_q.size), next: hbp_q.next};
        end else begin
          wdata = '{size: hp_q.size, next: bp_q};
        end
        rover_d  = p_q;
        status_d = ST_OK;
        state_d  = S_DONE;
      end
      S_F_RD_P2: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (status_q != ST_OK || kind_q == K_FREE) begin
          pay_d = '0;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== test/first_fit_free_list_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_top_tb
// Drives allocate and free commands, checks every result strobe against an
// in-bench free-list model or, for typed rows, the table. A directed table
// comes first, then random traffic over several split-minimum settings.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_top_tb
  import ffa_pkg::*;
();

  localparam int unsigned Arena = ArenaUnits;
  localparam int unsigned WatchdogLimit = 400000;
  localparam int unsigned NumRandom = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        kind_i;
  logic [17:0] request_bytes_i;
  logic [13:0] release_index_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [13:0] payload_index_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i;

  first_fit_free_list_allocator_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .request_bytes_i (request_bytes_i),
    .release_index_i (release_index_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .payload_index_o (payload_index_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One outstanding grant or verdict per command
  typedef struct {
    status_e     st;
    logic [13:0] pay;
  } grant_t;

  typedef struct {
    kind_e       k;
    logic [17:0] bytes;
    logic [13:0] idx;
    bit          typed;
    status_e     st;
    logic [13:0] pay;
  } cmd_row_t;

  grant_t pending_grants[$];
  int unsigned error_count;
  int unsigned idle_cycles;

  // Model of the header memory, rover and split minimum
  int unsigned blk_size [Arena];
  int unsigned blk_next [Arena];
  int unsigned rover_q;
  bit          headers_built;
  int unsigned split_min_q;
  logic [13:0] live_blocks[$];

  // Directed commands; typed results only where they follow at a glance
  cmd_row_t dir_rows [12] = '{
    '{K_ALLOC, 18'd0,      14'd0,     1'b1, ST_OK,      14'd16383},
    '{K_ALLOC, 18'd262143, 14'd0,     1'b1, ST_NOFIT,   14'd0},
    '{K_FREE,  18'd0,      14'd0,     1'b1, ST_NOTFREE, 14'd0},
    '{K_FREE,  18'd262143, 14'd1,     1'b1, ST_NOTFREE, 14'd0},
    '{K_FREE,  18'd0,      14'd16383, 1'b1, ST_OK,      14'd0},
    '{K_FREE,  18'd0,      14'd16383, 1'b1, ST_NOTFREE, 14'd0},
    '{K_ALLOC, 18'd16,     14'd0,     1'b1, ST_OK,      14'd16383},
    '{K_ALLOC, 18'd17,     14'd16383, 1'b0, ST_OK,      14'd0},
    '{K_FREE,  18'd0,      14'd16383, 1'b0, ST_OK,      14'd0},
    '{K_ALLOC, 18'd262112, 14'd0,     1'b0, ST_OK,      14'd0},
    '{K_ALLOC, 18'd0,      14'd0,     1'b0, ST_OK,      14'd0},
    '{K_FREE,  18'd0,      14'd2,     1'b0, ST_OK,      14'd0}
  };

  function automatic int unsigned wrap_unit(longint unsigned i);
    return int'(i % Arena);
  endfunction

  // First-fit grant from the rover; split the tail off a larger block
  function automatic void model_alloc(input logic [17:0] bytes, output status_e st,
                                      output logic [13:0] pay);
    longint unsigned want_units;
    int unsigned split, prev, p;
    want_units = ((bytes == 0 ? 1 : bytes) + UnitBytes - 1) / UnitBytes + 1;
    split = (split_min_q == 0) ? 1 : split_min_q;
    prev = rover_q;
    p = wrap_unit(blk_next[prev]);
    st = ST_NOFIT;
    pay = '0;
    for (int unsigned n = 0; n < Arena + 2; n++) begin
      if (blk_size[p] >= want_units) begin
        if (blk_size[p] - want_units < split) begin
          blk_next[prev] = blk_next[p];
        end else begin
          blk_size[p] -= int'(want_units);
          p = wrap_unit(longint'(p) + blk_size[p]);
          blk_size[p] = int'(want_units);
        end
        rover_q = prev;
        st = ST_OK;
        pay = 14'(wrap_unit(longint'(p) + 1));
        return;
      end
      if (p == rover_q) return;
      prev = p;
      p = wrap_unit(blk_next[p]);
    end
  endfunction

  // Ordered insert with merge on both sides; reject a block already free
  function automatic status_e model_free(input logic [13:0] idx);
    int unsigned hdr, p, q, n2;
    bit found;
    found = 1'b0;
    if (idx < 2) return ST_NOTFREE;
    hdr = idx - 1;
    p = rover_q;
    for (int unsigned n = 0; n < Arena + 2; n++) begin
      q = wrap_unit(blk_next[p]);
      if (p <= hdr && longint'(p) + blk_size[p] > hdr) return ST_NOTFREE;
      if ((hdr > p && hdr < q) || (p >= q && hdr > p)) begin
        found = 1'b1;
        break;
      end
      p = q;
    end
    if (!found) return ST_NOTFREE;
    n2 = wrap_unit(blk_next[p]);
    if (longint'(hdr) + blk_size[hdr] == n2) begin
      blk_size[hdr] += blk_size[n2];
      blk_next[hdr] = wrap_unit(blk_next[n2]);
    end else begin
      blk_next[hdr] = n2;
    end
    if (longint'(p) + blk_size[p] == hdr) begin
      blk_size[p] += blk_size[hdr];
      blk_next[p] = blk_next[hdr];
    end else begin
      blk_next[p] = hdr;
    end
    rover_q = p;
    return ST_OK;
  endfunction

  // True when the unit lies inside a block on the free list
  function automatic bit unit_is_free(input int unsigned u);
    int unsigned p;
    p = 0;
    for (int unsigned n = 0; n < Arena + 2; n++) begin
      if (p <= u && p + blk_size[p] > u) return 1'b1;
      p = blk_next[p];
      if (p == 0) return 1'b0;
    end
    return 1'b0;
  endfunction

  // Update the model for an accepted command and track live grants
  function automatic grant_t predict_grant(input kind_e k, input logic [17:0] bytes,
                                           input logic [13:0] idx);
    grant_t g;
    if (!headers_built) begin
      blk_size[0] = 0;
      blk_next[0] = 1;
      blk_size[1] = Arena - 1;
      blk_next[1] = 0;
      rover_q = 0;
      headers_built = 1'b1;
    end
    g.pay = '0;
    if (k == K_ALLOC) begin
      model_alloc(bytes, g.st, g.pay);
      if (g.st == ST_OK) live_blocks.push_back(g.pay);
    end else begin
      g.st = model_free(idx);
      if (g.st == ST_OK) begin
        foreach (live_blocks[i]) begin
          if (live_blocks[i] == idx) begin
            live_blocks.delete(i);
            break;
          end
        end
      end
    end
    return g;
  endfunction

  // Hold the command until its transfer, then record the expected result
  task automatic issue_cmd(input kind_e k, input logic [17:0] bytes,
                           input logic [13:0] idx, input bit typed,
                           input status_e st, input logic [13:0] pay);
    grant_t g;
    start_i         <= 1'b1;
    kind_i          <= k;
    request_bytes_i <= bytes;
    release_index_i <= idx;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    g = predict_grant(k, bytes, idx);
    if (typed) begin
      g.st = st;
      g.pay = pay;
    end
    pending_grants.push_back(g);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  // Write the split minimum only once the block has gone idle
  task automatic write_split_min(input logic [6:0] value);
    drain_results();
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    split_min_q = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Compare each result strobe with the oldest expectation; run the watchdog
  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_grants.size() == 0) begin
          $error("unexpected result: status %0d payload_index %0d", status_o,
                 payload_index_o);
          error_count++;
        end else begin
          g = pending_grants.pop_front();
          if (status_o !== g.st) begin
            $error("status: expected %0d, got %0d", g.st, status_o);
            error_count++;
          end
          if (payload_index_o !== g.pay) begin
            $error("payload_index: expected %0d, got %0d", g.pay, payload_index_o);
            error_count++;
          end
        end
      end
      if (done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [6:0] split_plan [5] = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd2};
    int unsigned burst, pick, sent, u;
    logic [17:0] bytes;

    error_count     = 0;
    idle_cycles     = 0;
    headers_built   = 1'b0;
    rover_q         = 0;
    split_min_q     = 2;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    kind_i          = K_ALLOC;
    request_bytes_i = '0;
    release_index_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = 7'd2;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset split minimum
    foreach (dir_rows[i]) begin
      issue_cmd(dir_rows[i].k, dir_rows[i].bytes, dir_rows[i].idx, dir_rows[i].typed,
                dir_rows[i].st, dir_rows[i].pay);
    end

    // Random traffic, one phase per split-minimum setting
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_split_min(ph == 4 ? 7'($urandom_range(1, 127)) : split_plan[ph]);
      while (sent < (ph + 1) * NumRandom / 5) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst; b++) begin
          pick = $urandom_range(0, 99);
          if (pick < 45 && live_blocks.size() != 0) begin
            u = $urandom_range(0, live_blocks.size() - 1);
            issue_cmd(K_FREE, 18'($urandom), live_blocks[u], 1'b0, ST_OK, '0);
          end else if (pick < 52) begin
            // free of a unit already on the free list, or of the sentinel range
            u = $urandom_range(0, 16383);
            if (u >= 2 && !unit_is_free(u - 1)) u = $urandom_range(0, 1);
            issue_cmd(K_FREE, 18'($urandom), 14'(u), 1'b0, ST_OK, '0);
          end else begin
            if (pick < 90) bytes = 18'($urandom_range(0, 200));
            else if (pick < 97) bytes = 18'($urandom_range(0, 4096));
            else bytes = 18'($urandom);
            issue_cmd(K_ALLOC, bytes, 14'($urandom), 1'b0, ST_OK, '0);
          end
          sent++;
          if (sent == NumRandom / 2) drain_results();
        end
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
